/* sv/sit_pkg.sv */
// shared types and constants for the sorted insert table
`timescale 1ns / 1ps

package sit_pkg;

  localparam logic [6:0] MONTH_MAX = 7'd12;
  localparam logic [6:0] DAY_MAX   = 7'd31;
  localparam logic [6:0] HOUR_MAX  = 7'd24;

  typedef enum logic [0:0] {
    MODE_INSERT = 1'b0,
    MODE_READ   = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_DATE_RANGE = 3'd1,
    ST_HOUR_RANGE = 3'd2,
    ST_FULL       = 3'd3,
    ST_END_MARK   = 3'd4,
    ST_READ_OK    = 3'd5,
    ST_IDX_EMPTY  = 3'd6
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [31:0] payload;
    logic [5:0]  read_index;
  } cmd_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  position;
    logic [6:0]  entry_count;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [31:0] out_payload;
  } rsp_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_CMP,
    S_RDWAIT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd_scan;
    logic    rd_index;
    logic    shift_wr;
    logic    place_wr;
    logic    set_status;
    status_t status;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic full;
    logic bad_date;
    logic end_mark;
    logic bad_hour;
    logic idx_ok;
    logic j_zero;
    logic new_lt;
    logic out_free;
  } ctrl_stat_t;

endpackage

/* sv/sit_if.sv */
// valid/ready channel interface carrying one transaction payload
`timescale 1ns / 1ps

interface sit_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* sv/sit_ctrl.sv */
// controller state machine for the sorted insert table
`timescale 1ns / 1ps

module sit_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sit_pkg::ctrl_stat_t stat,
  output sit_pkg::ctrl_cmd_t  ctl
);

  sit_pkg::state_t state;
  sit_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sit_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    ctl.status = sit_pkg::ST_INSERTED;
    in_ready   = 1'b0;
    case (state)
      sit_pkg::S_IDLE: begin
        in_ready = !rst;
        if (in_valid && in_ready) begin
          ctl.load   = 1'b1;
          state_next = sit_pkg::S_CHECK;
        end
      end
      sit_pkg::S_CHECK: begin
        if (stat.is_read) begin
          ctl.rd_index = 1'b1;
          state_next   = sit_pkg::S_RDWAIT;
        end else if (stat.full) begin
          ctl.set_status = 1'b1;
          ctl.status     = sit_pkg::ST_FULL;
          state_next     = sit_pkg::S_FINISH;
        end else if (stat.bad_date) begin
          ctl.set_status = 1'b1;
          ctl.status     = sit_pkg::ST_DATE_RANGE;
          state_next     = sit_pkg::S_FINISH;
        end else if (stat.end_mark) begin
          ctl.set_status = 1'b1;
          ctl.status     = sit_pkg::ST_END_MARK;
          state_next     = sit_pkg::S_FINISH;
        end else if (stat.bad_hour) begin
          ctl.set_status = 1'b1;
          ctl.status     = sit_pkg::ST_HOUR_RANGE;
          state_next     = sit_pkg::S_FINISH;
        end else begin
          state_next = sit_pkg::S_SCAN;
        end
      end
      sit_pkg::S_SCAN: begin
        if (stat.j_zero) begin
          ctl.place_wr   = 1'b1;
          ctl.set_status = 1'b1;
          ctl.status     = sit_pkg::ST_INSERTED;
          state_next     = sit_pkg::S_FINISH;
        end else begin
          ctl.rd_scan = 1'b1;
          state_next  = sit_pkg::S_CMP;
        end
      end
      sit_pkg::S_CMP: begin
        if (stat.new_lt) begin
          ctl.shift_wr = 1'b1;
          state_next   = sit_pkg::S_SCAN;
        end else begin
          ctl.place_wr   = 1'b1;
          ctl.set_status = 1'b1;
          ctl.status     = sit_pkg::ST_INSERTED;
          state_next     = sit_pkg::S_FINISH;
        end
      end
      sit_pkg::S_RDWAIT: begin
        ctl.set_status = 1'b1;
        ctl.status     = stat.idx_ok ? sit_pkg::ST_READ_OK : sit_pkg::ST_IDX_EMPTY;
        state_next     = sit_pkg::S_FINISH;
      end
      sit_pkg::S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = sit_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sit_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* sv/sit_datapath.sv */
// entry memory, counters, key compare and output register
`timescale 1ns / 1ps

module sit_datapath #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  sit_pkg::cmd_item_t  in_data,
  input  sit_pkg::ctrl_cmd_t  ctl,
  output sit_pkg::ctrl_stat_t stat,
  output sit_pkg::rsp_item_t  out_data,
  output logic                out_valid,
  input  logic                out_ready
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 6) ? CW : 6;
  localparam int PB = PAYLOAD_BITS;
  localparam int EW = PB + 14;

  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic [EW-1:0] wr_data;
  logic [EW-1:0] new_entry;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic          mem_re;

  sit_pkg::cmd_item_t item;
  sit_pkg::status_t   status;
  sit_pkg::rsp_item_t out_next;
  logic [CW-1:0]      count;
  logic [CW-1:0]      j;
  logic [CW-1:0]      jm1;
  logic [XW-1:0]      ridx_x;
  logic [13:0]        new_key;
  logic [13:0]        rd_key;

  assign jm1       = j - CW'(1);
  assign ridx_x    = XW'(item.read_index);
  assign new_key   = {item.month[3:0], item.day[4:0], item.hour[4:0]};
  assign rd_key    = rd_data[EW-1:PB];
  assign new_entry = {new_key, PB'(item.payload)};
  assign mem_we    = ctl.shift_wr | ctl.place_wr;
  assign mem_re    = ctl.rd_scan | ctl.rd_index;
  assign wr_data   = ctl.shift_wr ? rd_data : new_entry;
  assign rd_addr   = ctl.rd_index ? ridx_x[AW-1:0] : jm1[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[j[AW-1:0]] <= wr_data;
    end
    if (mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    stat.is_read  = (item.mode == sit_pkg::MODE_READ);
    stat.full     = (count == CW'(CAPACITY));
    stat.bad_date = (item.day > sit_pkg::DAY_MAX) || (item.month > sit_pkg::MONTH_MAX);
    stat.end_mark = (item.month == 7'd0) && (item.day == 7'd0);
    stat.bad_hour = (item.hour > sit_pkg::HOUR_MAX);
    stat.idx_ok   = (ridx_x < XW'(count));
    stat.j_zero   = (j == '0);
    stat.new_lt   = (new_key < rd_key);
    stat.out_free = !out_valid || out_ready;
  end

  always_comb begin
    out_next             = '0;
    out_next.status      = status;
    out_next.entry_count = 7'(count);
    case (status)
      sit_pkg::ST_INSERTED: begin
        out_next.position = 6'(j);
      end
      sit_pkg::ST_READ_OK: begin
        out_next.position    = item.read_index;
        out_next.out_month   = rd_data[PB+13:PB+10];
        out_next.out_day     = rd_data[PB+9:PB+5];
        out_next.out_hour    = rd_data[PB+4:PB];
        out_next.out_payload = 32'(rd_data[PB-1:0]);
      end
      sit_pkg::ST_IDX_EMPTY: begin
        out_next.position = item.read_index;
      end
      default: begin
        out_next.position = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.place_wr) begin
        count <= count + CW'(1);
      end
      if (ctl.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item <= in_data;
      j    <= count;
    end else if (ctl.shift_wr) begin
      j <= jm1;
    end
    if (ctl.set_status) begin
      status <= ctl.status;
    end
    if (ctl.out_load) begin
      out_data <= out_next;
    end
  end

endmodule

/* sv/sorted_insert_table.sv */
// top level of the sorted insert table
// usage:
//   cmd carries one transaction per item: mode 0 inserts (month, day, hour,
//   payload) into the table, kept in ascending key order with a new entry
//   placed after any equal keys; mode 1 reads the entry at read_index
//   rsp returns exactly one transaction per item with a status code, the
//   position, the entry count after the item and, for a good read, the entry
// sequencing:
//   one item in work at a time; cmd.ready is high only while idle, and the
//   next item can be taken in the cycle after its result is loaded
//   rejected insert: check, then finish; read: check, read wait, then finish
//   insert: check, then a walk down from the end of the table that reads each
//   entry and moves it up one place while the new key is smaller, then the
//   write of the new entry; the entry memory does one read or write per cycle
// reset:
//   rst clears the entry count and the output valid flag; entry contents are
//   left as they are and only written positions are ever reported
// stall:
//   a result waits in the output register until rsp.ready; the next item can
//   be accepted meanwhile and holds in its final state until the slot frees
`timescale 1ns / 1ps

module sorted_insert_table #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  sit_chan_if.sink   cmd,
  sit_chan_if.source rsp
);

  sit_pkg::ctrl_cmd_t  ctl;
  sit_pkg::ctrl_stat_t stat;
  logic                in_ready;
  logic                out_valid;
  sit_pkg::rsp_item_t  out_data;

  sit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  sit_datapath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (cmd.data),
    .ctl       (ctl),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (rsp.ready)
  );

  assign cmd.ready = in_ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

/* sv/sit_checker.sv */
// port-level assertions for the sorted insert table
`timescale 1ns / 1ps

module sit_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input sit_pkg::rsp_item_t rsp_data
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second transaction taken while item in work");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.status != sit_pkg::ST_READ_OK) |->
      (rsp_data.out_month == 4'd0) && (rsp_data.out_day == 5'd0) &&
      (rsp_data.out_hour == 5'd0) && (rsp_data.out_payload == 32'd0))
    else $error("entry fields set on non-read result");

  a_reject_position: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((rsp_data.status == sit_pkg::ST_FULL) ||
                  (rsp_data.status == sit_pkg::ST_DATE_RANGE) ||
                  (rsp_data.status == sit_pkg::ST_HOUR_RANGE) ||
                  (rsp_data.status == sit_pkg::ST_END_MARK)) |->
      rsp_data.position == 6'd0)
    else $error("rejected insert with nonzero position");

endmodule

bind sorted_insert_table sit_checker u_sit_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
